>>> hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    // table geometry
    localparam int CAPACITY   = 128;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int GRP_SIZE   = 16;
    localparam int NUM_GRP    = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int KEY_W      = 32;
    localparam int PAY_W      = 32;
    localparam int OUT_CNT_W  = 8;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [PAY_W-1:0]        t_pay;
    typedef logic [CNT_W-1:0]        t_count;

    // request operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_EMPTY   = 2'd2,
        STS_MISSING = 2'd3
    } t_status;

    // request sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_FIN
    } t_state;

    // controls broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_key_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake       payload
// request   in         start / busy    i_operation, i_key, i_payload
// result    out        o_done strobe   o_status, o_found_key, o_found_payload,
//                                      o_entry_count
//
// a request is taken when start is high and busy is low; each passes through these steps:
// compare in every cell, registered group pick, shift of the cell row, and a
// one-cycle result strobe during which the next request may already be taken.
// the group pick step comes from the two-level match pick over the row of cells.
// reset clears the sequencer and the entry count; the cells need no clearing.
// the receiver cannot stall; o_done is high for exactly one cycle per request.

module sorted_key_table_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    i_operation,
    input  wire skt_pkg::t_key i_key,
    input  wire skt_pkg::t_pay i_payload,
    output logic               o_done,
    output logic [1:0]         o_status,
    output skt_pkg::t_key      o_found_key,
    output skt_pkg::t_pay      o_found_payload,
    output logic [7:0]         o_entry_count
);
    import skt_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_op        r_op;
    t_key       r_key;
    t_pay       r_pay;
    t_count     r_count;
    t_count     n_count;
    logic       r_done;
    t_status    r_status;
    t_status    n_status;
    t_key       r_fkey;
    t_key       n_fkey;
    t_pay       r_fpay;
    t_pay       n_fpay;
    t_cell_ctrl w_ctrl;

    logic [CAPACITY-1:0] w_less_now;
    logic [CAPACITY-1:0] w_less;
    logic [CAPACITY-1:0] w_hit;
    t_key                w_key [CAPACITY];
    t_pay                w_pay [CAPACITY];
    logic                w_found;
    t_key                w_pick_key;
    t_pay                w_pick_pay;
    logic                w_full;
    logic                w_empty;
    logic [CNT_W+OUT_CNT_W-1:0] w_count_ext;

    assign w_full  = (r_count == t_count'(CAPACITY));
    assign w_empty = (r_count == '0);

    // row of cells, each linked to both neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic  w_valid;
        logic  w_pl_now;
        logic  w_pl;
        t_key  w_lkey;
        t_pay  w_lpay;
        t_key  w_rkey;
        t_pay  w_rpay;

        assign w_valid = (t_count'(i) < r_count);

        if (i == 0) begin : g_first
            assign w_pl_now = 1'b1;
            assign w_pl     = 1'b1;
            assign w_lkey   = r_key;
            assign w_lpay   = r_pay;
        end else begin : g_mid
            assign w_pl_now = w_less_now[i-1];
            assign w_pl     = w_less[i-1];
            assign w_lkey   = w_key[i-1];
            assign w_lpay   = w_pay[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_rkey = '0;
            assign w_rpay = '0;
        end else begin : g_inner
            assign w_rkey = w_key[i+1];
            assign w_rpay = w_pay[i+1];
        end

        skt_cell u_cell (
            .i_clk           (i_clk),
            .i_ctrl          (w_ctrl),
            .i_valid         (w_valid),
            .i_req_key       (r_key),
            .i_req_pay       (r_pay),
            .i_prev_less_now (w_pl_now),
            .i_prev_less     (w_pl),
            .i_left_key      (w_lkey),
            .i_left_pay      (w_lpay),
            .i_right_key     (w_rkey),
            .i_right_pay     (w_rpay),
            .o_less_now      (w_less_now[i]),
            .o_less          (w_less[i]),
            .o_hit           (w_hit[i]),
            .o_key           (w_key[i]),
            .o_pay           (w_pay[i])
        );
    end

    // match pick over the row
    skt_pick u_pick (
        .i_clk   (i_clk),
        .i_en    (r_state == ST_GRP),
        .i_hit   (w_hit),
        .i_keys  (w_key),
        .i_pays  (w_pay),
        .o_found (w_found),
        .o_key   (w_pick_key),
        .o_pay   (w_pick_pay)
    );

    // sequencer state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == ST_FIN);
        end
    end

    // request and result holding registers
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op  <= t_op'(i_operation);
            r_key <= i_key;
            r_pay <= i_payload;
        end
        if (r_state == ST_FIN) begin
            r_status <= n_status;
            r_fkey   <= n_fkey;
            r_fpay   <= n_fpay;
        end
    end

    // next state, cell controls and result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = STS_OK;
        n_fkey   = '0;
        n_fpay   = '0;
        w_ctrl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                w_ctrl.cmp_en = 1'b1;
                n_state       = ST_GRP;
            end
            ST_GRP: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_IDLE;
                unique case (r_op)
                    OP_INSERT: begin
                        if (w_full) begin
                            n_status = STS_FULL;
                        end else begin
                            w_ctrl.ins_en = 1'b1;
                            n_count       = r_count + 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (w_empty) begin
                            n_status = STS_EMPTY;
                        end else if (w_found) begin
                            w_ctrl.rem_en = 1'b1;
                            n_count       = r_count - 1'b1;
                            n_fkey        = w_pick_key;
                            n_fpay        = w_pick_pay;
                        end else begin
                            n_status = STS_MISSING;
                        end
                    end
                    OP_LOOKUP: begin
                        if (w_found) begin
                            n_fkey = w_pick_key;
                            n_fpay = w_pick_pay;
                        end else begin
                            n_status = STS_MISSING;
                        end
                    end
                    default: begin
                        n_status = STS_OK;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_count_ext     = {{OUT_CNT_W{1'b0}}, r_count};
    assign busy            = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_found_key     = r_fkey;
    assign o_found_payload = r_fpay;
    assign o_entry_count   = w_count_ext[OUT_CNT_W-1:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("entry count above capacity");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_GRP |-> $onehot0(w_hit))
        else $error("more than one cell matched");

    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == ST_FIN)
        else $error("result strobe without finished request");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && (r_status == STS_FULL) |-> w_full)
        else $error("full status with free slots");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && (r_status != STS_OK) |-> (r_fkey == '0) && (r_fpay == '0))
        else $error("failed request returned entry data");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken without going busy");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/skt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_cell (
    input  wire logic              i_clk,
    input  wire skt_pkg::t_cell_ctrl i_ctrl,
    input  wire logic              i_valid,
    input  wire skt_pkg::t_key     i_req_key,
    input  wire skt_pkg::t_pay     i_req_pay,
    input  wire logic              i_prev_less_now,
    input  wire logic              i_prev_less,
    input  wire skt_pkg::t_key     i_left_key,
    input  wire skt_pkg::t_pay     i_left_pay,
    input  wire skt_pkg::t_key     i_right_key,
    input  wire skt_pkg::t_pay     i_right_pay,
    output logic                   o_less_now,
    output logic                   o_less,
    output logic                   o_hit,
    output skt_pkg::t_key          o_key,
    output skt_pkg::t_pay          o_pay
);
    import skt_pkg::*;

    t_key r_key;
    t_pay r_pay;
    logic r_less;
    logic r_hit;

    // stored key below the request key
    assign o_less_now = i_valid && (r_key < i_req_key);

    // compare flags, then insert or remove shift
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_less <= o_less_now;
            r_hit  <= i_valid && (r_key == i_req_key) && !o_less_now && i_prev_less_now;
        end
        if (i_ctrl.ins_en) begin
            if (!r_less) begin
                if (i_prev_less) begin
                    r_key <= i_req_key;
                    r_pay <= i_req_pay;
                end else begin
                    r_key <= i_left_key;
                    r_pay <= i_left_pay;
                end
            end
        end else if (i_ctrl.rem_en) begin
            if (!r_less) begin
                r_key <= i_right_key;
                r_pay <= i_right_pay;
            end
        end
    end

    assign o_less = r_less;
    assign o_hit  = r_hit;
    assign o_key  = r_key;
    assign o_pay  = r_pay;

endmodule

`default_nettype wire

>>> hw/rtl/skt_pick.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_pick (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [skt_pkg::CAPACITY-1:0] i_hit,
    input  wire skt_pkg::t_key                i_keys [skt_pkg::CAPACITY],
    input  wire skt_pkg::t_pay                i_pays [skt_pkg::CAPACITY],
    output logic                              o_found,
    output skt_pkg::t_key                     o_key,
    output skt_pkg::t_pay                     o_pay
);
    import skt_pkg::*;

    logic [NUM_GRP-1:0] r_ghit;
    t_key               r_gkey [NUM_GRP];
    t_pay               r_gpay [NUM_GRP];
    logic [NUM_GRP-1:0] n_ghit;
    t_key               n_gkey [NUM_GRP];
    t_pay               n_gpay [NUM_GRP];

    // first level: one-hot and-or inside each group of cells
    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_ghit[g] = 1'b0;
            n_gkey[g] = '0;
            n_gpay[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < CAPACITY) begin
                    if (i_hit[g * GRP_SIZE + j]) begin
                        n_ghit[g] = 1'b1;
                        n_gkey[g] = n_gkey[g] | i_keys[g * GRP_SIZE + j];
                        n_gpay[g] = n_gpay[g] | i_pays[g * GRP_SIZE + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ghit <= n_ghit;
            r_gkey <= n_gkey;
            r_gpay <= n_gpay;
        end
    end

    // second level: merge the registered groups
    always_comb begin
        o_found = 1'b0;
        o_key   = '0;
        o_pay   = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            if (r_ghit[g]) begin
                o_found = 1'b1;
                o_key   = o_key | r_gkey[g];
                o_pay   = o_pay | r_gpay[g];
            end
        end
    end

endmodule

`default_nettype wire

>>> test/sorted_key_table_core_tb.sv
`timescale 1ns / 1ps

module sorted_key_table_core_tb;

    import skt_pkg::*;

    // one predicted result of a request
    typedef struct packed {
        logic [1:0] status;
        t_key       fkey;
        t_pay       fpay;
        logic [7:0] count;
    } t_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] i_operation = OP_NOP;
    t_key       i_key = '0;
    t_pay       i_payload = '0;
    logic       busy;
    logic       o_done;
    logic [1:0] o_status;
    t_key       o_found_key;
    t_pay       o_found_payload;
    logic [7:0] o_entry_count;

    // shadow copy of the table
    t_key    tbl_keys [CAPACITY];
    t_pay    tbl_pays [CAPACITY];
    int      tbl_count = 0;
    int      peak_count = 0;

    t_result pending_results [$];
    t_result oldest_result;
    int      error_count = 0;
    int      results_seen = 0;
    int      op_sent [4] = '{0, 0, 0, 0};
    int      sts_seen [4] = '{0, 0, 0, 0};
    bit      no_idle = 1'b0;

    sorted_key_table_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_key           (i_key),
        .i_payload       (i_payload),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_found_key     (o_found_key),
        .o_found_payload (o_found_payload),
        .o_entry_count   (o_entry_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // first slot whose key is not below the given key
    function automatic int first_not_below(input t_key key);
        int idx;
        idx = 0;
        while (idx < tbl_count && tbl_keys[idx] < key) idx++;
        return idx;
    endfunction

    // apply one request to the shadow table and return its result
    function automatic t_result apply_table_op(input logic [1:0] op, input t_key key,
                                               input t_pay pay);
        t_result res;
        int      idx;
        int      j;
        res.status = STS_OK;
        res.fkey   = '0;
        res.fpay   = '0;
        case (op)
            OP_INSERT: begin
                if (tbl_count >= CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    idx = first_not_below(key);
                    for (j = tbl_count; j > idx; j--) begin
                        tbl_keys[j] = tbl_keys[j-1];
                        tbl_pays[j] = tbl_pays[j-1];
                    end
                    tbl_keys[idx] = key;
                    tbl_pays[idx] = pay;
                    tbl_count++;
                    if (tbl_count > peak_count) peak_count = tbl_count;
                end
            end
            OP_REMOVE: begin
                if (tbl_count == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    idx = first_not_below(key);
                    if (idx >= tbl_count || tbl_keys[idx] != key) begin
                        res.status = STS_MISSING;
                    end else begin
                        res.fkey = tbl_keys[idx];
                        res.fpay = tbl_pays[idx];
                        for (j = idx; j + 1 < tbl_count; j++) begin
                            tbl_keys[j] = tbl_keys[j+1];
                            tbl_pays[j] = tbl_pays[j+1];
                        end
                        tbl_count--;
                    end
                end
            end
            OP_LOOKUP: begin
                idx = first_not_below(key);
                if (idx >= tbl_count || tbl_keys[idx] != key) begin
                    res.status = STS_MISSING;
                end else begin
                    res.fkey = tbl_keys[idx];
                    res.fpay = tbl_pays[idx];
                end
            end
            default: begin
            end
        endcase
        res.count = tbl_count[7:0];
        return res;
    endfunction

    // idle length before a request, mostly short
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 50) return 0;
        if (r < 82) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // key from a small pool, the extremes or the full range
    function automatic t_key pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return t_key'(int'($urandom_range(0, 8)) - 4);
        if (r < 50) begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh8000_0001;
                2: return 32'sh7fff_ffff;
                3: return 32'sh7fff_fffe;
                4: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return t_key'($urandom);
    endfunction

    // mostly a key that is stored, else any key
    function automatic t_key pick_stored_key(input int hit_pct);
        if (tbl_count > 0 && $urandom_range(0, 99) < hit_pct) begin
            return tbl_keys[$urandom_range(0, tbl_count - 1)];
        end
        return pick_key();
    endfunction

    // send one request and record its predicted result
    task automatic send_request(input logic [1:0] op, input t_key key, input t_pay pay);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_payload   <= pay;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_results.push_back(apply_table_op(op, key, pay));
        op_sent[op]++;
    endtask

    // random request with the given insert / remove / lookup weights, else a no-op
    task automatic send_random_request(input int ins_w, input int rem_w, input int lkp_w);
        int r;
        r = $urandom_range(0, ins_w + rem_w + lkp_w + 4);
        if (r < ins_w) begin
            send_request(OP_INSERT, pick_key(), t_pay'($urandom));
        end else if (r < ins_w + rem_w) begin
            send_request(OP_REMOVE, pick_stored_key(70), t_pay'($urandom));
        end else if (r < ins_w + rem_w + lkp_w) begin
            send_request(OP_LOOKUP, pick_stored_key(70), t_pay'($urandom));
        end else begin
            send_request(OP_NOP, t_key'($urandom), t_pay'($urandom));
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                log_failure("result strobe with no request outstanding");
            end else begin
                oldest_result = pending_results.pop_front();
                sts_seen[oldest_result.status]++;
                if (o_status !== oldest_result.status
                        || o_found_key !== oldest_result.fkey
                        || o_found_payload !== oldest_result.fpay
                        || o_entry_count !== oldest_result.count) begin
                    log_failure({
                        $sformatf("mismatch at %0t: exp sts=%0d key=%h pay=%h cnt=%0d, ",
                                  $realtime, oldest_result.status, oldest_result.fkey,
                                  oldest_result.fpay, oldest_result.count),
                        $sformatf("got sts=%0d key=%h pay=%h cnt=%0d",
                                  o_status, o_found_key, o_found_payload,
                                  o_entry_count)});
                end
            end
        end
    end

    // empty table, extremes, duplicates, absent keys and no-op
    task automatic test_directed();
        send_request(OP_LOOKUP, 32'sd0, 32'h0);
        send_request(OP_REMOVE, 32'sd5, 32'h0);
        send_request(OP_NOP, 32'shffff_ffff, 32'hffff_ffff);
        send_request(OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
        send_request(OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
        send_request(OP_INSERT, 32'sd0, 32'haaaa_5555);
        send_request(OP_INSERT, 32'sd0, 32'h5555_aaaa);
        send_request(OP_INSERT, -32'sd1, 32'h1234_5678);
        send_request(OP_LOOKUP, 32'sd0, 32'hffff_ffff);
        send_request(OP_REMOVE, 32'sd0, 32'h0);
        send_request(OP_LOOKUP, 32'sd0, 32'h0);
        send_request(OP_LOOKUP, 32'sd1, 32'h0);
        send_request(OP_REMOVE, 32'sd1, 32'h0);
        send_request(OP_LOOKUP, 32'sh7fff_ffff, 32'h0);
        send_request(OP_LOOKUP, 32'sh8000_0000, 32'h0);
        send_request(OP_NOP, 32'sd0, 32'h0);
        send_request(OP_REMOVE, 32'sh7fff_ffff, 32'h0);
        send_request(OP_REMOVE, 32'sh8000_0000, 32'h0);
        send_request(OP_REMOVE, 32'sd0, 32'h0);
        send_request(OP_REMOVE, -32'sd1, 32'h0);
        send_request(OP_REMOVE, 32'sd0, 32'h0);
        send_request(OP_LOOKUP, 32'sh8000_0000, 32'h0);
    endtask

    // random mix at low occupancy with frequent duplicates
    task automatic test_random_mix();
        int n;
        for (n = 0; n < 60; n++) begin
            if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_random_request(40, 30, 25);
        end
        no_idle = 1'b0;
    endtask

    // fill to capacity, then inserts into the full table
    task automatic test_fill_to_capacity();
        int n;
        while (tbl_count < CAPACITY) begin
            if (tbl_count % 32 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_request(OP_INSERT, pick_key(), t_pay'($urandom));
        end
        no_idle = 1'b0;
        for (n = 0; n < 6; n++) begin
            send_request(OP_INSERT, pick_key(), t_pay'($urandom));
        end
    endtask

    // mixed requests that keep the table at or near full
    task automatic test_near_full();
        int n;
        for (n = 0; n < 40; n++) begin
            send_random_request(45, 25, 25);
        end
    endtask

    // remove stored entries, with some lookups, until empty, then remove and look up in the empty table
    task automatic test_drain();
        int n;
        n = 0;
        while (tbl_count > 0) begin
            if (n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8) begin
                send_request(OP_REMOVE, pick_stored_key(95), t_pay'($urandom));
            end else begin
                send_request(OP_LOOKUP, pick_stored_key(60), t_pay'($urandom));
            end
            n++;
        end
        no_idle = 1'b0;
        send_request(OP_REMOVE, pick_key(), t_pay'($urandom));
        send_request(OP_LOOKUP, pick_key(), t_pay'($urandom));
    endtask

    // main sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix();
        test_fill_to_capacity();
        test_near_full();
        test_drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("sent %0d requests: %0d insert, %0d remove, %0d lookup, %0d no-op; %0d results",
                 op_sent[0] + op_sent[1] + op_sent[2] + op_sent[3], op_sent[0], op_sent[1],
                 op_sent[2], op_sent[3], results_seen);
        $display("outcomes ok %0d, full %0d, empty %0d, missing %0d; peak fill %0d of %0d",
                 sts_seen[0], sts_seen[1], sts_seen[2], sts_seen[3], peak_count, CAPACITY);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures", error_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
